// ===== hdl/cbsg_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsg_pkg: shared types and constants for the color bar sweep generator
// Word formats, geometry bundle, back-end states and the bar palette.
// ----------------------------------------------------------------------------
package cbsg_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int ColW      = 12;                 // column / row counters
  localparam int DimW      = 13;                 // frame_width / frame_height
  localparam int IdxW      = 32;                 // frame_index
  localparam int ProdW     = IdxW + 3;           // frame_index * 6
  localparam int ProdCntW  = $clog2(ProdW);
  localparam int BarW      = DimW - 3;           // width / 8
  localparam int SweepW    = 7;                  // width / 40, at most 102
  localparam int CfgIdxW   = 1;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  typedef struct packed {
    logic            frame_start;
    logic [IdxW-1:0] frame_index;
  } item_t;

  typedef struct packed {
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic [ColW-1:0] column;
    logic            line_end;
    logic            frame_end;
  } pixel_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] product;
  } job_t;

  // effective frame geometry
  typedef struct packed {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [BarW-1:0]   bar_w;
    logic [SweepW-1:0] sweep_w;
  } geom_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MOD,
    BK_FIRST
  } back_state_t;

  // {blue, green, red} per bar: grey, yellow, cyan, green, magenta, red, blue, black
  function automatic logic [23:0] bar_color(input logic [2:0] bar);
    logic [23:0] c;
    unique case (bar)
      3'd0:    c = {8'd192, 8'd192, 8'd192};
      3'd1:    c = {8'd0,   8'd192, 8'd192};
      3'd2:    c = {8'd192, 8'd192, 8'd0  };
      3'd3:    c = {8'd0,   8'd192, 8'd0  };
      3'd4:    c = {8'd192, 8'd0,   8'd192};
      3'd5:    c = {8'd0,   8'd0,   8'd192};
      3'd6:    c = {8'd192, 8'd0,   8'd0  };
      default: c = {8'd0,   8'd0,   8'd0  };
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/cbsg_front.sv =====
// ----------------------------------------------------------------------------
// cbsg_front: input stage
// Registers the incoming word, forms frame_index * 6 and tags frame starts.
// ----------------------------------------------------------------------------
module cbsg_front import cbsg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  job_valid,
  input  logic  job_ready,
  output job_t  job
);

  logic             full;
  job_t             hold;
  logic [ProdW-1:0] idx_ext;

  assign idx_ext    = ProdW'(item.frame_index);
  assign item_ready = !full || job_ready;
  assign job_valid  = full;
  assign job        = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_ready) begin
      full <= item_valid;
    end
  end

  // x*6 = x*4 + x*2
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold.start   <= item.frame_start;
      hold.product <= (idx_ext << 2) + (idx_ext << 1);
    end
  end

endmodule

// ===== hdl/cbsg_fifo.sv =====
// ----------------------------------------------------------------------------
// cbsg_fifo: short job queue
// Decouples the front stage from the pixel back end.
// ----------------------------------------------------------------------------
module cbsg_fifo import cbsg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = count != FifoCntW'(FifoDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cbsg_back.sv =====
// ----------------------------------------------------------------------------
// cbsg_back: pixel engine
// Raster counters, bit-serial sweep position remainder, output register.
// ----------------------------------------------------------------------------
module cbsg_back import cbsg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  geom_t  geom,
  input  logic   job_valid,
  output logic   job_ready,
  input  job_t   job,
  output logic   pixel_valid,
  input  logic   pixel_ready,
  output pixel_t pixel
);

  back_state_t         state;
  back_state_t         state_next;
  logic [ProdCntW-1:0] bit_cnt;
  logic [ProdW-1:0]    prod_sh;
  logic [ColW-1:0]     rem;
  logic [ColW-1:0]     column_count;
  logic [ColW-1:0]     row_count;
  logic [2:0]          bar_number;
  logic [ColW-1:0]     column_in_bar;
  logic [ColW-1:0]     sweep_left;
  logic                out_full;
  pixel_t              out_word;

  logic                slot_free;
  logic                emit;
  logic                mod_load;
  logic                mod_step;
  logic                mod_last;
  logic [DimW-1:0]     trial;
  logic [ColW-1:0]     rem_next;
  logic                white;
  logic                lend;
  logic                fend;
  logic [DimW-1:0]     sweep_end;
  logic [ColW-1:0]     cib_inc;
  logic [23:0]         color;

  assign slot_free = !out_full || pixel_ready;
  assign mod_last  = bit_cnt == '0;

  // restoring remainder step: one product bit per cycle
  assign trial    = {1'b0, rem} << 1 | DimW'(prod_sh[ProdW-1]);
  assign rem_next = (trial >= geom.width) ? ColW'(trial - geom.width) : ColW'(trial);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (job_valid && job.start) state_next = BK_MOD;
      end
      BK_MOD: begin
        if (mod_last) state_next = BK_FIRST;
      end
      BK_FIRST: begin
        if (slot_free) state_next = BK_RUN;
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    mod_load = 1'b0;
    mod_step = 1'b0;
    unique case (state)
      BK_RUN: begin
        mod_load = job_valid && job.start;
        emit     = job_valid && !job.start && slot_free;
      end
      BK_MOD:   mod_step = 1'b1;
      BK_FIRST: emit = slot_free;
      default: ;
    endcase
  end

  assign job_ready = emit;

  // current pixel
  assign sweep_end = DimW'(sweep_left) + DimW'(geom.sweep_w);
  assign white     = (column_count >= sweep_left) && (DimW'(column_count) < sweep_end);
  assign lend      = DimW'(column_count) >= geom.width - 1'b1;
  assign fend      = lend && (DimW'(row_count) >= geom.height - 1'b1);
  assign color     = bar_color(bar_number);
  assign cib_inc   = column_in_bar + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_load) begin
      bit_cnt <= ProdCntW'(ProdW - 1);
      prod_sh <= job.product;
      rem     <= '0;
    end else if (mod_step) begin
      bit_cnt <= bit_cnt - 1'b1;
      prod_sh <= prod_sh << 1;
      rem     <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      bar_number    <= '0;
      column_in_bar <= '0;
      sweep_left    <= '0;
    end else if (mod_step && mod_last) begin
      column_count  <= '0;
      row_count     <= '0;
      bar_number    <= '0;
      column_in_bar <= '0;
      sweep_left    <= rem_next;
    end else if (emit) begin
      if (lend) begin
        column_count  <= '0;
        bar_number    <= '0;
        column_in_bar <= '0;
        row_count     <= fend ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
        if (cib_inc >= ColW'(geom.bar_w)) begin
          column_in_bar <= '0;
          if (bar_number != 3'd7) bar_number <= bar_number + 1'b1;
        end else begin
          column_in_bar <= cib_inc;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (slot_free) begin
      out_full <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.blue      <= white ? 8'hFF : color[23:16];
      out_word.green     <= white ? 8'hFF : color[15:8];
      out_word.red       <= white ? 8'hFF : color[7:0];
      out_word.column    <= column_count;
      out_word.line_end  <= lend;
      out_word.frame_end <= fend;
    end
  end

  assign pixel_valid = out_full;
  assign pixel       = out_word;

endmodule

// ===== hdl/color_bar_sweep_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// color_bar_sweep_pattern_generator: eight color bars with a white sweep bar
// One pixel word out for each input word, in raster order.
// ----------------------------------------------------------------------------
// Path: input register in the front stage, job queue, then the pixel output register.
// Throughput: 1 word per cycle while pixel_ready is high; a frame_start word holds
//   the back end while the bit-serial remainder (frame_index*6) mod width runs
//   over all 35 product bits, one bit a cycle.
// Reset (rst, synchronous): width 640, height 480, counters and sweep at 0,
//   queue and output register empty.
module color_bar_sweep_pattern_generator import cbsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               pixel_valid,
  input  logic               pixel_ready,
  output pixel_t             pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DimW-1:0]    cfg_data
);

  logic [DimW-1:0]       frame_width;
  logic [DimW-1:0]       frame_height;
  geom_t                 geom;
  logic [BarW-1:0]       eighth;
  logic [BarW+8-1:0]     fifth_prod;
  logic [SweepW-1:0]     fortieth;

  logic                  fj_valid;
  logic                  fj_ready;
  job_t                  fj;
  logic                  bj_valid;
  logic                  bj_ready;
  job_t                  bj;

  // Config writes always land; the user must write them only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WidthReset;
      frame_height <= HeightReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWidth:  frame_width  <= cfg_data;
        RegHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry: zero reads as 1, oversize clamps to the maximum.
  always_comb begin
    if (frame_width == '0) begin
      geom.width = DimW'(1);
    end else if (frame_width > DimW'(MaxWidth)) begin
      geom.width = DimW'(MaxWidth);
    end else begin
      geom.width = frame_width;
    end
    if (frame_height == '0) begin
      geom.height = DimW'(1);
    end else if (frame_height > DimW'(MaxHeight)) begin
      geom.height = DimW'(MaxHeight);
    end else begin
      geom.height = frame_height;
    end

    // Bar width = w/8 (min 1). Sweep width = (w/8)/5 via *205>>10, exact for
    // w/8 below 1024; 2 columns when that comes out zero.
    eighth       = BarW'(geom.width >> 3);
    fifth_prod   = (BarW+8)'(eighth) * (BarW+8)'(205);
    fortieth     = SweepW'(fifth_prod >> 10);
    geom.bar_w   = (eighth == '0) ? BarW'(1) : eighth;
    geom.sweep_w = (fortieth == '0) ? SweepW'(2) : fortieth;
  end

  // front: register word, form index*6, tag frame start
  cbsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (fj_valid),
    .job_ready  (fj_ready),
    .job        (fj)
  );

  // two-entry queue that lets the front take words while the back end divides, until it fills
  cbsg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj)
  );

  // back: sweep remainder, raster counters, pixel output register
  cbsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .job_valid   (bj_valid),
    .job_ready   (bj_ready),
    .job         (bj),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

endmodule

// ===== tb/color_bar_sweep_pattern_generator_tb.sv =====
// ----------------------------------------------------------------------------
// color_bar_sweep_pattern_generator_tb: self-checking bench for the bar generator
// A scripted opening covers reset state, width and height extremes, clamped
// geometry and frame restarts. Random phases follow, each with a fresh frame
// geometry and random pacing on both sides; one phase forces backpressure. Every pixel
// word is checked against a cycle-free predictor of the raster and sweep logic or a literal.
// ----------------------------------------------------------------------------
module color_bar_sweep_pattern_generator_tb;
  import cbsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;   // receiver hold-off in the pressure phase
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PHASE_WORDS = 140;
  localparam int unsigned PRESS_PHASE = 4;     // receiver stalls, sender floods
  localparam int unsigned PAUSE_PHASE = 6;     // sender drains halfway through the phase
  localparam int unsigned SETTLE      = 10;    // idle time after the final drain
  localparam logic [DimW-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DimW-1:0] RESET_HEIGHT = 13'd480;

  // {blue, green, red}: grey, yellow, cyan, green, magenta, red, blue, black
  localparam logic [23:0] BAR_BGR [8] = '{
    24'hC0C0C0, 24'h00C0C0, 24'hC0C000, 24'h00C000,
    24'hC000C0, 24'h0000C0, 24'hC00000, 24'h000000
  };

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_t;

  typedef struct packed {
    row_kind_t       kind;
    logic            frame_start;
    logic [IdxW-1:0] frame_index;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            typed;        // 1: expected pixel is the literal below
    pixel_t          pix;
    logic [4:0]      repeats;
  } step_row_t;

  localparam pixel_t WHITE_COL0 = '{8'd255, 8'd255, 8'd255, 12'd0, 1'b0, 1'b0};
  localparam pixel_t WHITE_COL1 = '{8'd255, 8'd255, 8'd255, 12'd1, 1'b0, 1'b0};
  localparam pixel_t GREY_COL0  = '{8'd192, 8'd192, 8'd192, 12'd0, 1'b0, 1'b0};
  localparam pixel_t ONE_PIXEL  = '{8'd255, 8'd255, 8'd255, 12'd0, 1'b1, 1'b1};
  localparam pixel_t NO_PIX     = '0;

  // Opening script. Untyped rows are checked against the predictor.
  localparam int unsigned SCRIPT_ROWS = 16;
  localparam step_row_t SCRIPT [SCRIPT_ROWS] = '{
    // out of reset, no frame start: sweep at column 0, 16 wide
    '{ROW_WORD, 1'b0, 32'h0000_0000, 13'd0,    13'd0,    1'b1, WHITE_COL0, 5'd1},
    '{ROW_WORD, 1'b0, 32'hFFFF_FFFF, 13'd0,    13'd0,    1'b1, WHITE_COL1, 5'd1},
    // largest frame index, then sweep parked against the right edge
    '{ROW_WORD, 1'b1, 32'hFFFF_FFFF, 13'd0,    13'd0,    1'b0, NO_PIX,     5'd1},
    '{ROW_WORD, 1'b1, 32'd106,       13'd0,    13'd0,    1'b1, GREY_COL0,  5'd1},
    // 8x2 frame: one column per bar, sweep cut off at column 7
    '{ROW_CFG,  1'b0, 32'h0,         13'd8,    13'd2,    1'b0, NO_PIX,     5'd0},
    '{ROW_WORD, 1'b1, 32'd1,         13'd0,    13'd0,    1'b0, NO_PIX,     5'd1},
    '{ROW_WORD, 1'b0, 32'h5555_5555, 13'd0,    13'd0,    1'b0, NO_PIX,     5'd15},
    // single-pixel frames, then width and height of zero taken as one
    '{ROW_CFG,  1'b0, 32'h0,         13'd1,    13'd1,    1'b0, NO_PIX,     5'd0},
    '{ROW_WORD, 1'b1, 32'd5,         13'd0,    13'd0,    1'b1, ONE_PIXEL,  5'd1},
    '{ROW_CFG,  1'b0, 32'h0,         13'd0,    13'd0,    1'b0, NO_PIX,     5'd0},
    '{ROW_WORD, 1'b1, 32'd3,         13'd0,    13'd0,    1'b1, ONE_PIXEL,  5'd1},
    '{ROW_WORD, 1'b0, 32'hAAAA_AAAA, 13'd0,    13'd0,    1'b1, ONE_PIXEL,  5'd1},
    // all-ones geometry clamps to 4096 x 4096
    '{ROW_CFG,  1'b0, 32'h0,         13'h1FFF, 13'h1FFF, 1'b0, NO_PIX,     5'd0},
    '{ROW_WORD, 1'b1, 32'd0,         13'd0,    13'd0,    1'b1, WHITE_COL0, 5'd1},
    '{ROW_WORD, 1'b1, 32'h2AAA_AAAB, 13'd0,    13'd0,    1'b0, NO_PIX,     5'd1},
    '{ROW_WORD, 1'b0, 32'h0,         13'd0,    13'd0,    1'b0, NO_PIX,     5'd1}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               pixel_valid;
  logic               pixel_ready;
  pixel_t             pixel;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DimW-1:0]    cfg_data;

  color_bar_sweep_pattern_generator dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: geometry as written, and the raster position of the
  // next pixel.
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  logic [ColW-1:0] col_cnt;
  logic [ColW-1:0] row_cnt;
  logic [2:0]      bar_idx;
  logic [ColW-1:0] pos_in_bar;
  logic [ColW-1:0] sweep_start;

  pixel_t      pending_pixels[$];   // expected pixel words, oldest first
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned holds_asked = 0;     // sender asks, receiver serves
  int unsigned holds_done = 0;

  // Raster and sweep predictor: returns the pixel for one accepted word and
  // advances the position.
  function automatic pixel_t paint_pixel(input logic fs, input logic [IdxW-1:0] idx);
    int unsigned       wd, ht, bar_len, sweep_len, col;
    longint unsigned   prod;
    logic [23:0]       bgr;
    bit                white, last_col, last_row;
    pixel_t            p;
    // zero reads as one, oversize is clamped
    wd = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
    ht = (height_reg == 0) ? 1 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
    bar_len   = (wd / 8 > 0) ? wd / 8 : 1;
    sweep_len = (wd / 40 > 0) ? wd / 40 : 2;
    if (fs) begin
      col_cnt    = '0;
      row_cnt    = '0;
      bar_idx    = '0;
      pos_in_bar = '0;
      prod       = longint'(idx) * 64'd6;
      sweep_start = ColW'(prod % longint'(wd));
    end
    col      = col_cnt;
    bgr      = BAR_BGR[bar_idx];
    // sweep is cut at the right edge, never wraps
    white    = (col >= sweep_start) && (col < sweep_start + sweep_len);
    last_col = col >= wd - 1;
    last_row = last_col && (row_cnt >= ht - 1);
    p.blue      = white ? 8'hFF : bgr[23:16];
    p.green     = white ? 8'hFF : bgr[15:8];
    p.red       = white ? 8'hFF : bgr[7:0];
    p.column    = col_cnt;
    p.line_end  = last_col;
    p.frame_end = last_row;
    if (last_col) begin
      col_cnt    = '0;
      bar_idx    = '0;
      pos_in_bar = '0;
      row_cnt    = last_row ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt    = col_cnt + 1'b1;
      pos_in_bar = pos_in_bar + 1'b1;
      if (pos_in_bar >= bar_len) begin
        pos_in_bar = '0;
        if (bar_idx < 3'd7) bar_idx = bar_idx + 1'b1;   // black holds to the end
      end
    end
    return p;
  endfunction

  function automatic int unsigned draw_gap(input pace_t pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 18);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic pace_t draw_pace();
    case ($urandom_range(0, 2))
      0:       return PACE_FULL;
      1:       return PACE_RANDOM;
      default: return PACE_BURSTY;
    endcase
  endfunction

  // Geometry menu: mostly small frames so lines and frames close often,
  // with the clamped and extreme values mixed in.
  function automatic logic [DimW-1:0] draw_dim(input bit is_width);
    case ($urandom_range(0, 15))
      0:       return DimW'(1);
      1:       return DimW'(MaxWidth);
      2:       return '0;
      3:       return DimW'($urandom_range(MaxWidth + 1, 8191));
      4:       return DimW'($urandom_range(100, MaxWidth));
      default: return is_width ? DimW'($urandom_range(1, 96)) : DimW'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [IdxW-1:0] draw_index();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return IdxW'($urandom_range(0, 20));   // sweep near the left edge
      default: return $urandom;
    endcase
  endfunction

  // Wait until every expected pixel is back; drop valid first so the last
  // word is not taken twice.
  task automatic drain_pixels();
    if (pending_pixels.size() != 0) begin
      item_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clk);
    end
  endtask

  // Both registers in one go, only while the block is idle.
  task automatic write_geometry(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    drain_pixels();
    cfg_valid <= 1'b1;
    cfg_index <= RegWidth;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    cfg_index <= RegHeight;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  // Offer one input word after an optional gap; valid stays up past the
  // accept so back-to-back words need no toggle.
  task automatic send_word(input logic fs, input logic [IdxW-1:0] idx,
                           input int unsigned gap, input bit typed, input pixel_t typed_pix);
    pixel_t predicted;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{frame_start: fs, frame_index: idx};
    do @(posedge clk); while (!item_ready);
    predicted = paint_pixel(fs, idx);
    pending_pixels.push_back(typed ? typed_pix : predicted);
  endtask

  // Receiver: a random stall before each word, plus the long hold-off when
  // the sender asks for one.
  initial begin : pixel_sink
    int unsigned stall;
    pace_t       sink_pace;
    sink_pace   = PACE_RANDOM;
    pixel_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        pixel_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = draw_gap(sink_pace);
      if (stall != 0) begin
        pixel_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_ready <= 1'b1;
      do @(posedge clk); while (!pixel_valid);
      if ($urandom_range(0, 63) == 0) sink_pace = draw_pace();
    end
  end

  // Pixel checker
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pixel_valid && pixel_ready) begin
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected pixel word: b=%0d g=%0d r=%0d col=%0d le=%0b fe=%0b",
                   pixel.blue, pixel.green, pixel.red, pixel.column,
                   pixel.line_end, pixel.frame_end);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel.blue !== want.blue || pixel.green !== want.green ||
            pixel.red !== want.red || pixel.column !== want.column ||
            pixel.line_end !== want.line_end || pixel.frame_end !== want.frame_end) begin
          if (mismatches < 10)
            $display("pixel mismatch: want b=%0d g=%0d r=%0d col=%0d le=%0b fe=%0b, got b=%0d g=%0d r=%0d col=%0d le=%0b fe=%0b",
                     want.blue, want.green, want.red, want.column,
                     want.line_end, want.frame_end,
                     pixel.blue, pixel.green, pixel.red, pixel.column,
                     pixel.line_end, pixel.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on total run length
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("color_bar_sweep_pattern_generator_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    step_row_t       row;
    logic [DimW-1:0] w, h;
    logic            fs;
    pace_t           src_pace;
    int unsigned     gap;

    // every input known from time zero
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = RegWidth;
    cfg_data   = '0;

    width_reg   = RESET_WIDTH;
    height_reg  = RESET_HEIGHT;
    col_cnt     = '0;
    row_cnt     = '0;
    bar_idx     = '0;
    pos_in_bar  = '0;
    sweep_start = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // scripted opening, back to back
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      row = SCRIPT[i];
      if (row.kind == ROW_CFG) begin
        write_geometry(row.width, row.height);
      end else begin
        for (int r = 0; r < row.repeats; r++)
          send_word(row.frame_start, row.frame_index, 0, row.typed, row.pix);
      end
    end

    // random phases: new geometry each phase, counters carry over so a
    // geometry change lands mid-frame unless a frame start follows
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      w = draw_dim(1'b1);
      h = draw_dim(1'b0);
      if (ph == 1) begin
        w = DimW'(MaxWidth);
        h = DimW'(MaxHeight);
      end else if (ph == 2) begin
        w = DimW'(1);
        h = DimW'(1);
      end
      write_geometry(w, h);
      src_pace = draw_pace();
      if (ph == PRESS_PHASE) begin
        src_pace = PACE_FULL;
        holds_asked++;      // receiver parks; the block fills and stalls input
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_WORDS / 2) drain_pixels();
        // mostly well-formed frames: restart at the top, rare stray restarts
        if (col_cnt == 0 && row_cnt == 0) fs = ($urandom_range(0, 3) != 0);
        else                              fs = ($urandom_range(0, 49) == 0);
        gap = draw_gap(src_pace);
        send_word(fs, draw_index(), gap, 1'b0, NO_PIX);
        if (ph != PRESS_PHASE && $urandom_range(0, 47) == 0) src_pace = draw_pace();
      end
    end

    drain_pixels();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("color_bar_sweep_pattern_generator_tb: done, clean");
    else
      $display("color_bar_sweep_pattern_generator_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cbsg_pkg.sv
hdl/cbsg_front.sv
hdl/cbsg_fifo.sv
hdl/cbsg_back.sv
hdl/color_bar_sweep_pattern_generator.sv
tb/color_bar_sweep_pattern_generator_tb.sv
